### hdl/ldb_pkg.sv
// Shared types, constants and register codes of the ladder input debouncer.
package ldb_pkg;

    localparam int CHANNEL_W          = 2;
    localparam int NUM_CHANNELS       = 1 << CHANNEL_W;
    localparam int INPUTS_PER_CHANNEL = 3;
    localparam int NUM_THRESHOLDS     = 7;
    localparam int THRESH_REGS        = 7;
    localparam int SAMPLE_W           = 12;
    localparam int COUNT_W            = 8;
    localparam int MASK_W             = 3;
    localparam int INPUT_IDX_W        = 2;
    localparam int STATES_W           = 3;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 12;
    localparam int S_TDATA_W          = 16;
    localparam int M_TDATA_W          = 8;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_THRESH_0       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESH_6       = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_STEPS = 3'd7;

    typedef logic [THRESH_REGS-1:0][SAMPLE_W-1:0]       t_thresh_arr;
    typedef logic [INPUTS_PER_CHANNEL-1:0][COUNT_W-1:0] t_cnt_row;
    typedef logic [INPUTS_PER_CHANNEL-1:0]              t_lvl_row;

    localparam t_thresh_arr THRESH_RESET = {
        12'd3584, 12'd3072, 12'd2560, 12'd2048, 12'd1536, 12'd1024, 12'd512
    };
    localparam logic [COUNT_W-1:0] STEPS_RESET = 8'd8;

    typedef struct packed {
        t_thresh_arr        thresh;
        logic [COUNT_W-1:0] steps;
    } t_cfg;

    typedef struct packed {
        logic                   seen;
        logic [INPUT_IDX_W-1:0] which;
        logic                   level;
    } t_upd_result;

endpackage

### hdl/ldb_cfg_regs.sv
// Configuration register bank: ladder thresholds and debounce limit.
module ldb_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [ldb_pkg::CFG_INDEX_W-1:0] i_index,
    input  logic [ldb_pkg::CFG_DATA_W-1:0]  i_data,
    output ldb_pkg::t_cfg                   o_cfg
);
    import ldb_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresh <= THRESH_RESET;
            r_cfg.steps  <= STEPS_RESET;
        end else if (i_wr_en) begin
            unique case (i_index) inside
                [REG_THRESH_0:REG_THRESH_6]: begin
                    r_cfg.thresh[i_index] <= i_data[SAMPLE_W-1:0];
                end
                REG_DEBOUNCE_STEPS: begin
                    r_cfg.steps <= i_data[COUNT_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/ldb_ladder.sv
// Ladder decode: index of the first threshold that the sample lies below.
module ldb_ladder (
    input  logic [ldb_pkg::SAMPLE_W-1:0] i_sample,
    input  ldb_pkg::t_thresh_arr         i_thresh,
    output logic [ldb_pkg::MASK_W-1:0]   o_mask
);
    import ldb_pkg::*;

    always_comb begin
        o_mask = MASK_W'(NUM_THRESHOLDS);
        // walk downward so the lowest failing threshold wins
        for (int k = NUM_THRESHOLDS - 1; k >= 0; k--) begin
            if (i_sample < i_thresh[k]) begin
                o_mask = MASK_W'(k);
            end
        end
    end

endmodule

### hdl/ldb_update.sv
// Debounce update of one channel's counters and levels, scan stops at first change.
module ldb_update (
    input  logic [ldb_pkg::MASK_W-1:0]  i_mask,
    input  logic [ldb_pkg::COUNT_W-1:0] i_steps,
    input  ldb_pkg::t_cnt_row           i_cnt,
    input  ldb_pkg::t_lvl_row           i_lvl,
    output ldb_pkg::t_cnt_row           o_cnt,
    output ldb_pkg::t_lvl_row           o_lvl,
    output ldb_pkg::t_upd_result        o_res
);
    import ldb_pkg::*;

    always_comb begin
        logic stop;
        stop  = 1'b0;
        o_cnt = i_cnt;
        o_lvl = i_lvl;
        o_res = '0;
        for (int i = 0; i < INPUTS_PER_CHANNEL; i++) begin
            if (!stop) begin
                if (i_mask[i] && (o_cnt[i] < i_steps)) begin
                    o_cnt[i] = o_cnt[i] + 8'd1;
                    if ((o_cnt[i] == i_steps) && !o_lvl[i]) begin
                        o_lvl[i]    = 1'b1;
                        stop        = 1'b1;
                        o_res.seen  = 1'b1;
                        o_res.which = INPUT_IDX_W'(i);
                        o_res.level = 1'b1;
                    end
                end else if (!i_mask[i] && (o_cnt[i] != '0)) begin
                    o_cnt[i] = o_cnt[i] - 8'd1;
                    if ((o_cnt[i] == '0) && o_lvl[i]) begin
                        o_lvl[i]    = 1'b0;
                        stop        = 1'b1;
                        o_res.seen  = 1'b1;
                        o_res.which = INPUT_IDX_W'(i);
                        o_res.level = 1'b0;
                    end
                end
            end
        end
    end

endmodule

### hdl/ladder_input_debouncer.sv
// Top level of the resistor-ladder switch decoder with per-input debounce.
//
//  channel   direction  ports                       request contents
//  --------  ---------  --------------------------  ----------------------------------
//  s stream  in         i_s_tvalid/o_s_tready       tuser: channel_index[1:0]
//                                                   tdata: sample_value[11:0], zero pad
//  m stream  out        o_m_tvalid/i_m_tready       tdata: change_seen, changed_input,
//                                                   new_level, debounced_states, pad
//  cfg       in         i_cfg_wr_en                 index 0..6 thresholds, 7 limit
//
//  One request per cycle sustained while i_m_tready stays high; o_m_tvalid is the result register.
//  The rate is set by the single decode-and-update pass between the input register
//  and the result register; the state row of a channel is read and written back in
//  that same cycle, so consecutive requests for one channel need no forwarding.
//  Synchronous active-low reset clears all counters, levels and valid flags and
//  restores the register defaults. A stall on the output holds both stages;
//  o_s_tready stays high while the input stage is empty or about to advance.
module ladder_input_debouncer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // cfg write port
    input  logic                            i_cfg_wr_en,
    input  logic [ldb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ldb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // sample stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [ldb_pkg::S_TDATA_W-1:0]   i_s_tdata,  // [11:0] sample_value, [15:12] zero
    input  logic [ldb_pkg::CHANNEL_W-1:0]   i_s_tuser,  // [1:0] channel_index
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ldb_pkg::M_TDATA_W-1:0]   o_m_tdata   // [0] change_seen, [2:1] changed_input,
                                                        // [3] new_level, [6:4] debounced_states,
                                                        // [7] zero
);
    import ldb_pkg::*;

    t_cfg cfg;

    ldb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Input stage
    logic                 r_in_valid;
    logic [CHANNEL_W-1:0] r_ch;
    logic [SAMPLE_W-1:0]  r_sample;

    // Result stage
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    // Debounce state, one row per channel
    t_cnt_row r_cnt [NUM_CHANNELS];
    t_lvl_row r_lvl [NUM_CHANNELS];

    logic adv;

    // Advance the input stage into the result register when that register is free
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Payload: load on every request taken
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_ch     <= i_s_tuser;
            r_sample <= i_s_tdata[SAMPLE_W-1:0];
        end
    end

    // Decode and debounce pass
    logic [MASK_W-1:0] mask;
    t_cnt_row          cnt_row;
    t_lvl_row          lvl_row;
    t_cnt_row          n_cnt_row;
    t_lvl_row          n_lvl_row;
    t_upd_result       res;
    logic [STATES_W-1:0] states;

    assign cnt_row = r_cnt[r_ch];
    assign lvl_row = r_lvl[r_ch];

    ldb_ladder u_ladder (
        .i_sample (r_sample),
        .i_thresh (cfg.thresh),
        .o_mask   (mask)
    );

    ldb_update u_update (
        .i_mask  (mask),
        .i_steps (cfg.steps),
        .i_cnt   (cnt_row),
        .i_lvl   (lvl_row),
        .o_cnt   (n_cnt_row),
        .o_lvl   (n_lvl_row),
        .o_res   (res)
    );

    // Pad the level row out to the result field
    always_comb begin
        states = '0;
        for (int i = 0; i < INPUTS_PER_CHANNEL; i++) begin
            states[i] = n_lvl_row[i];
        end
    end

    // Write back the channel row as the result is registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_cnt[c] <= '0;
                r_lvl[c] <= '0;
            end
        end else if (adv) begin
            r_cnt[r_ch] <= n_cnt_row;
            r_lvl[r_ch] <= n_lvl_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {1'b0, states, res.level, res.which, res.seen};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // At most one level of the channel flips per request
    a_one_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> $countones(r_lvl[$past(r_ch)] ^ $past(lvl_row)) <= 1)
        else $error("more than one debounced level changed in one request");

    // No reported change means the levels of that channel hold
    a_quiet_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !res.seen) |=> r_lvl[$past(r_ch)] == $past(lvl_row))
        else $error("level changed without a reported change");

    // A waiting input request is neither lost nor altered
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_ch) && $stable(r_sample)))
        else $error("stalled input stage lost its request");

endmodule

### dv/ldb_checker.sv
// Scoreboard for the ladder input debouncer: mirrors its state and checks every result.
module ldb_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ldb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ldb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [ldb_pkg::S_TDATA_W-1:0]   i_s_tdata,  // [11:0] sample_value, [15:12] zero
    input  logic [ldb_pkg::CHANNEL_W-1:0]   i_s_tuser,  // [1:0] channel_index
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [ldb_pkg::M_TDATA_W-1:0]   i_m_tdata,  // [0] change_seen, [2:1] changed_input,
                                                        // [3] new_level, [6:4] debounced_states
    output int                              o_errors,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ldb_pkg::*;

    localparam int SLOTS = NUM_CHANNELS * INPUTS_PER_CHANNEL;

    // Laid out to match the result tdata bit for bit
    typedef struct packed {
        logic                   pad;
        logic [STATES_W-1:0]    states;
        logic                   level;
        logic [INPUT_IDX_W-1:0] which;
        logic                   seen;
    } t_ldb_result;

    logic [SAMPLE_W-1:0] ladder_copy [THRESH_REGS];
    logic [COUNT_W-1:0]  limit_copy;
    logic [COUNT_W-1:0]  bounce_cnt [SLOTS];
    logic                stable_lvl [SLOTS];
    t_ldb_result         awaited_results [$];
    int                  errors = 0;

    // Decode one sample into its ladder mask and advance the channel's counters.
    function automatic t_ldb_result debounce_sample(input logic [CHANNEL_W-1:0] ch,
                                                    input logic [SAMPLE_W-1:0] smp);
        t_ldb_result       r;
        logic [MASK_W-1:0] mask;
        int                slot;
        logic              done;
        r    = '0;
        mask = '0;
        done = 1'b0;
        for (int k = 0; k < NUM_THRESHOLDS; k++) begin
            if (!done) begin
                if (smp >= ladder_copy[k])
                    mask = mask + 1'b1;
                else
                    done = 1'b1;
            end
        end
        done = 1'b0;
        for (int i = 0; i < INPUTS_PER_CHANNEL; i++) begin
            slot = int'(ch) * INPUTS_PER_CHANNEL + i;
            if (!done && mask[i] && bounce_cnt[slot] < limit_copy) begin
                bounce_cnt[slot] = bounce_cnt[slot] + 1'b1;
                if (bounce_cnt[slot] == limit_copy && !stable_lvl[slot]) begin
                    stable_lvl[slot] = 1'b1;
                    r.seen  = 1'b1;
                    r.which = INPUT_IDX_W'(i);
                    r.level = 1'b1;
                    done    = 1'b1;
                end
            end
            if (!done && !mask[i] && bounce_cnt[slot] > 0) begin
                bounce_cnt[slot] = bounce_cnt[slot] - 1'b1;
                if (bounce_cnt[slot] == 0 && stable_lvl[slot]) begin
                    stable_lvl[slot] = 1'b0;
                    r.seen  = 1'b1;
                    r.which = INPUT_IDX_W'(i);
                    r.level = 1'b0;
                    done    = 1'b1;
                end
            end
        end
        for (int i = 0; i < INPUTS_PER_CHANNEL; i++)
            r.states[i] = stable_lvl[int'(ch) * INPUTS_PER_CHANNEL + i];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_ldb_result got;
        t_ldb_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < THRESH_REGS; k++)
                ladder_copy[k] = THRESH_RESET[k];
            limit_copy = STEPS_RESET;
            for (int s = 0; s < SLOTS; s++) begin
                bounce_cnt[s] = '0;
                stable_lvl[s] = 1'b0;
            end
            awaited_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (awaited_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result %h with nothing awaited", $realtime,
                                 i_m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.seen !== want.seen || got.which !== want.which ||
                        got.level !== want.level || got.states !== want.states) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: result mismatch: expected seen %0d input %0d ",
                                      "level %0d states %b, got seen %0d input %0d ",
                                      "level %0d states %b"}, $realtime,
                                     want.seen, want.which, want.level, want.states,
                                     got.seen, got.which, got.level, got.states);
                    end
                end
            end
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_DEBOUNCE_STEPS)
                    limit_copy = i_cfg_data[COUNT_W-1:0];
                else
                    ladder_copy[i_cfg_index - REG_THRESH_0] = i_cfg_data[SAMPLE_W-1:0];
            end
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(debounce_sample(i_s_tuser,
                                                          i_s_tdata[SAMPLE_W-1:0]));
        end
        o_errors  <= errors;
        o_pending <= awaited_results.size();
    end

endmodule

### dv/testbench.sv
// Top of the ladder input debouncer test: clock, reset, stimulus phases and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ldb_pkg::*;

    // Longest legal stretch without any handshake is the receiver's long hold plus a
    // few bursts of idling; allow several times that before calling it a hang.
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_GAP      = 13;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata   = '0;   // [11:0] sample_value, [15:12] zero
    logic [CHANNEL_W-1:0]   i_s_tuser   = '0;   // [1:0] channel_index
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;          // [0] change_seen, [2:1] changed_input,
                                                // [3] new_level, [6:4] debounced_states

    int   mismatches;
    int   outstanding;
    int   tx_gap_pct   = 0;     // chance in percent of a sender gap before a request
    int   rx_gap_pct   = 0;     // chance in percent of a receiver stall burst
    bit   quiet_tail   = 1'b0;  // no idling on either side once set
    bit   hold_request = 1'b0;  // ask the receiver for one long hold
    bit   hold_taken   = 1'b0;  // the receiver has served the long hold
    int   limit_now    = STEPS_RESET;
    int   quiet_cycles = 0;

    logic [SAMPLE_W-1:0] ladder [THRESH_REGS];

    ladder_input_debouncer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    ldb_checker scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .o_errors    (mismatches),
        .o_pending   (outstanding)
    );

    always begin
        #2ns i_clk = 1'b1;
        #2ns i_clk = 1'b0;
    end

    // Hang detector: count cycles in which neither stream moves a request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[ladder_input_debouncer] ERROR");
                $finish;
            end
        end
    end

    // Result sink: mostly ready, with stall bursts whose density drifts over the run.
    // One long hold, counted here, lets the pipeline fill and back-pressure the input.
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 99) < rx_gap_pct) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
            end
            if ($urandom_range(0, 63) == 0) begin
                case ($urandom_range(0, 2))
                    0:       rx_gap_pct = 0;
                    1:       rx_gap_pct = 10;
                    default: rx_gap_pct = 35;
                endcase
            end
            i_m_tready <= 1'b1;
        end
    end

    // Offer one sample request and hold it until the block takes it. Valid stays high
    // on return so that a following request can go straight out on the next edge.
    task automatic push_sample(input logic [CHANNEL_W-1:0] ch,
                               input logic [SAMPLE_W-1:0] smp);
        if (!quiet_tail && $urandom_range(0, 99) < tx_gap_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= ch;
        i_s_tdata  <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, smp};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    // Drop valid and wait for every awaited result, then let the pipeline empty out.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write enable is left high on return; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Load all seven thresholds from the ladder array, then the debounce limit.
    task automatic load_config(input int steps);
        for (int k = 0; k < THRESH_REGS; k++)
            write_reg(REG_THRESH_0 + CFG_INDEX_W'(k), CFG_DATA_W'(ladder[k]));
        write_reg(REG_DEBOUNCE_STEPS, CFG_DATA_W'(steps));
        i_cfg_wr_en <= 1'b0;
        limit_now = steps;
    endtask

    // Most requests come as runs of one sample on one channel, long enough around the
    // debounce limit to push counters to saturation and flip levels both ways. Lone
    // samples and stray requests inside a run supply the noise and broken runs.
    task automatic random_items(input int n);
        int                   left;
        int                   run_len;
        logic [CHANNEL_W-1:0] ch;
        logic [SAMPLE_W-1:0]  held_smp;
        left = n;
        while (left > 0) begin
            case ($urandom_range(0, 3))
                0:       tx_gap_pct = 0;
                1:       tx_gap_pct = 10;
                default: tx_gap_pct = 30;
            endcase
            ch       = CHANNEL_W'($urandom_range(0, NUM_CHANNELS - 1));
            held_smp = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            if ($urandom_range(0, 4) == 0)
                run_len = 1;
            else
                run_len = $urandom_range(1, limit_now + limit_now / 2 + 2);
            while (run_len > 0 && left > 0) begin
                if ($urandom_range(0, 11) == 0)
                    push_sample(CHANNEL_W'($urandom_range(0, NUM_CHANNELS - 1)),
                                SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
                else
                    push_sample(ch, held_smp);
                run_len--;
                left--;
            end
        end
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: range extremes and both sides of every reset threshold, spread
        // over all channels, with the register defaults still in place.
        push_sample(CHANNEL_W'(0), SAMPLE_W'(0));
        push_sample(CHANNEL_W'(3), SAMPLE_W'(SAMPLE_MAX));
        for (int k = 0; k < THRESH_REGS; k++) begin
            push_sample(CHANNEL_W'(k), THRESH_RESET[k] - 1'b1);
            push_sample(CHANNEL_W'(k + 1), THRESH_RESET[k]);
        end
        push_sample(CHANNEL_W'(1), SAMPLE_W'(12'h555));
        push_sample(CHANNEL_W'(2), SAMPLE_W'(12'hAAA));
        settle();

        // Limit of one: every matching sample flips a level at once. The receiver
        // holds off for a long stretch here while requests keep coming.
        for (int k = 0; k < THRESH_REGS; k++)
            ladder[k] = THRESH_RESET[k];
        load_config(1);
        hold_request = 1'b1;
        random_items(200);
        settle();

        // Zero limit: counters never climb, so only the decay path runs.
        load_config(0);
        random_items(100);
        settle();

        // Ordered random ladder with a mid-sized limit to build counters up...
        for (int k = 0; k < THRESH_REGS; k++)
            ladder[k] = SAMPLE_W'(k * 585 + $urandom_range(0, 584));
        load_config(40);
        random_items(300);
        settle();

        // ...then drop the limit beneath them: saturated counters must only decay.
        write_reg(REG_DEBOUNCE_STEPS, CFG_DATA_W'(3));
        i_cfg_wr_en <= 1'b0;
        limit_now = 3;
        random_items(150);
        settle();

        // Largest limit with the default ladder; long runs are needed to flip anything.
        for (int k = 0; k < THRESH_REGS; k++)
            ladder[k] = THRESH_RESET[k];
        load_config(255);
        random_items(600);
        settle();

        // All thresholds at full scale: only the top code reaches past mask 0.
        for (int k = 0; k < THRESH_REGS; k++)
            ladder[k] = SAMPLE_W'(SAMPLE_MAX);
        load_config(2);
        random_items(100);
        settle();

        // All thresholds at zero: every sample gives the full mask.
        for (int k = 0; k < THRESH_REGS; k++)
            ladder[k] = '0;
        load_config(2);
        random_items(100);
        settle();

        // Unordered ladder, small random limit; finish with both sides flat out.
        for (int k = 0; k < THRESH_REGS; k++)
            ladder[k] = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        load_config($urandom_range(1, 16));
        random_items(225);
        quiet_tail = 1'b1;
        random_items(150);
        settle();

        if (mismatches == 0)
            $display("[ladder_input_debouncer] OK");
        else
            $display("[ladder_input_debouncer] ERROR");
        $finish;
    end

endmodule
